### sv/hufb_pkg.sv
// ----------------------------------------------------------------------------
// hufb_pkg
// Types, request codes and bit helpers for the hierarchical used/free bitmap.
// ----------------------------------------------------------------------------
package hufb_pkg;

	localparam int NBITS_DEF = 32768;
	localparam int WORD_BITS = 32;
	localparam logic [31:0] MASK_ALL = 32'hffff_ffff;

	localparam logic [4:0] RQ_SET          = 5'd0;
	localparam logic [4:0] RQ_CLEAR        = 5'd1;
	localparam logic [4:0] RQ_READ         = 5'd2;
	localparam logic [4:0] RQ_LOW_FREE     = 5'd3;
	localparam logic [4:0] RQ_HIGH_FREE    = 5'd4;
	localparam logic [4:0] RQ_LOW_USED     = 5'd5;
	localparam logic [4:0] RQ_HIGH_USED    = 5'd6;
	localparam logic [4:0] RQ_NEXT_USED_UP = 5'd7;
	localparam logic [4:0] RQ_NEXT_USED_DN = 5'd8;
	localparam logic [4:0] RQ_NEXT_FREE_UP = 5'd9;
	localparam logic [4:0] RQ_NEXT_FREE_DN = 5'd10;
	localparam logic [4:0] RQ_TAKE_LOW     = 5'd11;
	localparam logic [4:0] RQ_RELEASE_LOW  = 5'd12;
	localparam logic [4:0] RQ_ALL_FREE     = 5'd13;
	localparam logic [4:0] RQ_ALL_USED     = 5'd14;
	localparam logic [4:0] RQ_TAKE_HIGH    = 5'd15;
	localparam logic [4:0] RQ_RELEASE_HIGH = 5'd16;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_SAME  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	typedef struct packed {
		logic [4:0]  req_type;
		logic [14:0] bit_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [14:0] found_index;
		logic        bit_value;
		logic [15:0] used_count;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_SET, OP_CLEAR, OP_READ, OP_SEARCH, OP_FILL
	} op_kind_t;

	typedef enum logic [1:0] {
		ACT_NONE, ACT_TAKE, ACT_RELEASE
	} act_t;

	typedef struct packed {
		op_kind_t    kind;
		logic        used;
		logic        up;
		act_t        act;
		logic        fill_used;
		logic [14:0] pivot;
		logic [1:0]  status;
		logic [14:0] found;
	} op_t;

	typedef struct packed {
		logic [15:0] size;
		logic        busy;
	} bk_stat_t;

	typedef enum logic [2:0] {
		B_IDLE, B_EVAL, B_MID, B_EVAL2, B_WRITE, B_FILL, B_OUT
	} bk_state_t;

	function automatic logic [4:0] lsb32(input logic [31:0] x);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (x[i]) r = 5'(i);
		end
		return r;
	endfunction

	function automatic logic [4:0] msb32(input logic [31:0] x);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) r = 5'(i);
		end
		return r;
	endfunction

	function automatic logic [4:0] pick_bit(input logic [31:0] x, input logic up);
		return up ? lsb32(x) : msb32(x);
	endfunction

	function automatic logic [31:0] vmask(input logic [9:0] w, input logic [15:0] n);
		logic [10:0] nw;
		logic [31:0] r;
		nw = n[15:5];
		if ({1'b0, w} < nw) r = MASK_ALL;
		else if ({1'b0, w} == nw) r = (32'd1 << n[4:0]) - 32'd1;
		else r = 32'd0;
		return r;
	endfunction

endpackage

### sv/hufb_front.sv
// ----------------------------------------------------------------------------
// hufb_front
// Accepts requests, checks range against the map size and classifies them.
// ----------------------------------------------------------------------------
module hufb_front (
	input  logic              req_valid,
	output logic              req_stall,
	input  hufb_pkg::req_t    req,
	input  hufb_pkg::bk_stat_t stat,
	input  logic              q_full,
	output logic              push,
	output hufb_pkg::op_t     push_op
);
	import hufb_pkg::*;

	logic        in_rng;
	logic        nz;
	logic [15:0] last16;

	assign in_rng = {1'b0, req.bit_index} < stat.size;
	assign nz     = stat.size != 16'd0;
	assign last16 = stat.size - 16'd1;

	assign req_stall = q_full || stat.busy;
	assign push      = req_valid && !req_stall;

	always_comb begin
		push_op           = '0;
		push_op.kind      = OP_NONE;
		push_op.act       = ACT_NONE;
		push_op.status    = ST_DONE;
		push_op.pivot     = req.bit_index;
		unique case (req.req_type) inside
			RQ_SET, RQ_CLEAR, RQ_READ: begin
				push_op.found = req.bit_index;
				if (!in_rng) push_op.status = ST_RANGE;
				else if (req.req_type == RQ_SET) push_op.kind = OP_SET;
				else if (req.req_type == RQ_CLEAR) push_op.kind = OP_CLEAR;
				else push_op.kind = OP_READ;
			end
			RQ_LOW_FREE, RQ_TAKE_LOW, RQ_LOW_USED, RQ_RELEASE_LOW: begin
				push_op.used  = (req.req_type == RQ_LOW_USED) || (req.req_type == RQ_RELEASE_LOW);
				push_op.up    = 1'b1;
				push_op.pivot = 15'd0;
				if (req.req_type == RQ_TAKE_LOW) push_op.act = ACT_TAKE;
				if (req.req_type == RQ_RELEASE_LOW) push_op.act = ACT_RELEASE;
				if (nz) push_op.kind = OP_SEARCH;
				else push_op.status = ST_NONE;
			end
			RQ_HIGH_FREE, RQ_TAKE_HIGH, RQ_HIGH_USED, RQ_RELEASE_HIGH: begin
				push_op.used  = (req.req_type == RQ_HIGH_USED) || (req.req_type == RQ_RELEASE_HIGH);
				push_op.up    = 1'b0;
				push_op.pivot = last16[14:0];
				if (req.req_type == RQ_TAKE_HIGH) push_op.act = ACT_TAKE;
				if (req.req_type == RQ_RELEASE_HIGH) push_op.act = ACT_RELEASE;
				if (nz) push_op.kind = OP_SEARCH;
				else push_op.status = ST_NONE;
			end
			RQ_NEXT_USED_UP, RQ_NEXT_USED_DN, RQ_NEXT_FREE_UP, RQ_NEXT_FREE_DN: begin
				push_op.used = (req.req_type == RQ_NEXT_USED_UP) || (req.req_type == RQ_NEXT_USED_DN);
				push_op.up   = (req.req_type == RQ_NEXT_USED_UP) || (req.req_type == RQ_NEXT_FREE_UP);
				if (in_rng) push_op.kind = OP_SEARCH;
				else begin
					push_op.status = ST_RANGE;
					push_op.found  = req.bit_index;
				end
			end
			RQ_ALL_FREE, RQ_ALL_USED: begin
				push_op.kind      = OP_FILL;
				push_op.fill_used = req.req_type == RQ_ALL_USED;
			end
			default: ;
		endcase
	end

endmodule

### sv/hufb_queue.sv
// ----------------------------------------------------------------------------
// hufb_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module hufb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hufb_pkg::op_t push_op,
	input  logic          pop,
	output hufb_pkg::op_t pop_op,
	output logic          full,
	output logic          empty
);
	import hufb_pkg::*;

	op_t        ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full   = cnt_q == 2'd2;
	assign empty  = cnt_q == 2'd0;
	assign pop_op = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_op;
	end

endmodule

### sv/hufb_back.sv
// ----------------------------------------------------------------------------
// hufb_back
// Executes requests against the leaf memory and the summary levels.
// ----------------------------------------------------------------------------
module hufb_back #(
	parameter int NBITS = hufb_pkg::NBITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr,
	input  logic [15:0]         cfg_data,
	input  logic                q_empty,
	input  hufb_pkg::op_t       q_op,
	output logic                pop,
	output hufb_pkg::bk_stat_t  stat,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output hufb_pkg::rsp_t      rsp
);
	import hufb_pkg::*;

	localparam int NWORDS  = (NBITS + WORD_BITS - 1) / WORD_BITS;
	localparam int NGROUPS = (NWORDS + 31) / 32;
	localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int GIDX_W  = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
	localparam logic [15:0] SIZE_MAX = 16'(NBITS);
	localparam logic [WADDR_W-1:0] SW_LAST = WADDR_W'(NWORDS - 1);

	bk_state_t state_q, state_d;
	op_t       op_q;
	logic [15:0] bits_q, used_q, size;
	logic [31:0] umid_q [NGROUPS];
	logic [31:0] fmid_q [NGROUPS];
	logic [NGROUPS-1:0] utop_q, ftop_q;
	logic [WADDR_W-1:0] sw_q;
	logic fill_used_q, fill_rsp_q, rsp_valid_q;
	logic [9:0]  tw_q;
	logic [4:0]  g2_q, bpos_q;
	logic [31:0] wd_q, rdata_q;
	logic [1:0]  status_q;
	logic [14:0] fnd_q;
	logic        val_q;
	rsp_t        rsp_q;
	logic [31:0] leaf_mem [NWORDS];

	logic [9:0]  pw, rd_addr, sw10, w2_mid, w2_top;
	logic [4:0]  pg, pb, wg, wb, sg, sb;
	logic [31:0] lw, m1, mrow, mm, topv, tm, mrow2, nw, vm_w, vm_s;
	logic [31:0] urow_n, frow_n;
	logic        slot_free, mem_we, cur_bit, do_set;
	logic [9:0]  mem_waddr;
	logic [31:0] mem_wdata;

	assign size   = (bits_q > SIZE_MAX) ? SIZE_MAX : bits_q;
	assign pw     = op_q.pivot[14:5];
	assign pg     = pw[9:5];
	assign pb     = op_q.pivot[4:0];
	assign lw     = op_q.used ? rdata_q : (~rdata_q & vmask(tw_q, size));
	assign m1     = lw & (op_q.up ? (MASK_ALL << pb) : (MASK_ALL >> (5'd31 - pb)));
	assign mrow   = op_q.used ? umid_q[pg[GIDX_W-1:0]] : fmid_q[pg[GIDX_W-1:0]];
	assign mm     = mrow & (op_q.up ? ((MASK_ALL << pw[4:0]) << 1)
		: ((MASK_ALL >> (5'd31 - pw[4:0])) >> 1));
	assign topv   = op_q.used ? 32'(utop_q) : 32'(ftop_q);
	assign tm     = topv & (op_q.up ? ((MASK_ALL << pg) << 1)
		: ((MASK_ALL >> (5'd31 - pg)) >> 1));
	assign mrow2  = op_q.used ? umid_q[g2_q[GIDX_W-1:0]] : fmid_q[g2_q[GIDX_W-1:0]];
	assign w2_mid = {pg, pick_bit(mm, op_q.up)};
	assign w2_top = {g2_q, pick_bit(mrow2, op_q.up)};
	assign cur_bit = rdata_q[pb];

	assign do_set = (op_q.kind == OP_SET) || (op_q.act == ACT_TAKE);
	assign nw     = do_set ? (wd_q | (32'd1 << bpos_q)) : (wd_q & ~(32'd1 << bpos_q));
	assign vm_w   = vmask(tw_q, size);
	assign wg     = tw_q[9:5];
	assign wb     = tw_q[4:0];
	assign sw10   = 10'(sw_q);
	assign sg     = sw10[9:5];
	assign sb     = sw10[4:0];
	assign vm_s   = vmask(sw10, size);

	always_comb begin
		urow_n     = umid_q[wg[GIDX_W-1:0]];
		frow_n     = fmid_q[wg[GIDX_W-1:0]];
		urow_n[wb] = nw != 32'd0;
		frow_n[wb] = (~nw & vm_w) != 32'd0;
	end

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign pop       = (state_q == B_IDLE) && !q_empty;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					unique case (q_op.kind)
						OP_NONE:  state_d = B_OUT;
						OP_FILL:  state_d = B_FILL;
						default:  state_d = B_EVAL;
					endcase
				end
			end
			B_EVAL: begin
				unique case (op_q.kind)
					OP_SET:    state_d = cur_bit ? B_OUT : B_WRITE;
					OP_CLEAR:  state_d = cur_bit ? B_WRITE : B_OUT;
					OP_SEARCH: begin
						if (m1 != 32'd0) state_d = (op_q.act != ACT_NONE) ? B_WRITE : B_OUT;
						else if (mm != 32'd0) state_d = B_EVAL2;
						else if (tm != 32'd0) state_d = B_MID;
						else state_d = B_OUT;
					end
					default:   state_d = B_OUT;
				endcase
			end
			B_MID:   state_d = (mrow2 != 32'd0) ? B_EVAL2 : B_OUT;
			B_EVAL2: state_d = ((lw != 32'd0) && (op_q.act != ACT_NONE)) ? B_WRITE : B_OUT;
			B_WRITE: state_d = B_OUT;
			B_FILL:  begin
				if (sw_q == SW_LAST) state_d = fill_rsp_q ? B_OUT : B_IDLE;
			end
			B_OUT:   begin
				if (slot_free) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
		if (cfg_wr) state_d = B_FILL;
	end

	// memory port control
	always_comb begin
		rd_addr   = tw_q;
		mem_we    = 1'b0;
		mem_waddr = tw_q;
		mem_wdata = nw;
		unique case (state_q)
			B_IDLE:  rd_addr = q_op.pivot[14:5];
			B_EVAL:  rd_addr = w2_mid;
			B_MID:   rd_addr = w2_top;
			B_WRITE: mem_we = 1'b1;
			B_FILL:  begin
				mem_we    = 1'b1;
				mem_waddr = sw10;
				mem_wdata = fill_used_q ? vm_s : 32'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) leaf_mem[mem_waddr[WADDR_W-1:0]] <= mem_wdata;
		rdata_q <= leaf_mem[rd_addr[WADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_FILL;
			bits_q      <= SIZE_MAX;
			used_q      <= 16'd0;
			sw_q        <= '0;
			fill_used_q <= 1'b0;
			fill_rsp_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			utop_q      <= '0;
			ftop_q      <= '0;
			for (int i = 0; i < NGROUPS; i++) begin
				umid_q[i] <= '0;
				fmid_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if ((state_q == B_OUT) && slot_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (cfg_wr) begin
				bits_q      <= cfg_data;
				fill_used_q <= 1'b0;
				fill_rsp_q  <= 1'b0;
				sw_q        <= '0;
				used_q      <= 16'd0;
				utop_q      <= '0;
				ftop_q      <= '0;
				for (int i = 0; i < NGROUPS; i++) begin
					umid_q[i] <= '0;
					fmid_q[i] <= '0;
				end
			end else begin
				unique case (state_q)
					B_IDLE: begin
						if (pop && (q_op.kind == OP_FILL)) begin
							fill_used_q <= q_op.fill_used;
							fill_rsp_q  <= 1'b1;
							sw_q        <= '0;
							used_q      <= q_op.fill_used ? size : 16'd0;
							utop_q      <= '0;
							ftop_q      <= '0;
							for (int i = 0; i < NGROUPS; i++) begin
								umid_q[i] <= '0;
								fmid_q[i] <= '0;
							end
						end
					end
					B_WRITE: begin
						umid_q[wg[GIDX_W-1:0]] <= urow_n;
						fmid_q[wg[GIDX_W-1:0]] <= frow_n;
						utop_q[wg[GIDX_W-1:0]] <= urow_n != 32'd0;
						ftop_q[wg[GIDX_W-1:0]] <= frow_n != 32'd0;
						used_q <= do_set ? (used_q + 16'd1) : (used_q - 16'd1);
					end
					B_FILL: begin
						if (vm_s != 32'd0) begin
							if (fill_used_q) begin
								umid_q[sg[GIDX_W-1:0]][sb] <= 1'b1;
								utop_q[sg[GIDX_W-1:0]]     <= 1'b1;
							end else begin
								fmid_q[sg[GIDX_W-1:0]][sb] <= 1'b1;
								ftop_q[sg[GIDX_W-1:0]]     <= 1'b1;
							end
						end
						sw_q <= sw_q + WADDR_W'(1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					op_q     <= q_op;
					tw_q     <= q_op.pivot[14:5];
					status_q <= q_op.status;
					fnd_q    <= q_op.found;
					val_q    <= 1'b0;
				end
			end
			B_EVAL: begin
				unique case (op_q.kind)
					OP_READ: val_q <= cur_bit;
					OP_SET, OP_CLEAR: begin
						if (cur_bit == (op_q.kind == OP_SET)) status_q <= ST_SAME;
						wd_q   <= rdata_q;
						bpos_q <= pb;
					end
					OP_SEARCH: begin
						if (m1 != 32'd0) begin
							fnd_q  <= {pw, pick_bit(m1, op_q.up)};
							bpos_q <= pick_bit(m1, op_q.up);
							wd_q   <= rdata_q;
						end else if (mm != 32'd0) begin
							tw_q <= w2_mid;
						end else if (tm != 32'd0) begin
							g2_q <= pick_bit(tm, op_q.up);
						end else begin
							status_q <= ST_NONE;
						end
					end
					default: ;
				endcase
			end
			B_MID: begin
				if (mrow2 != 32'd0) tw_q <= w2_top;
				else status_q <= ST_NONE;
			end
			B_EVAL2: begin
				if (lw != 32'd0) begin
					fnd_q  <= {tw_q, pick_bit(lw, op_q.up)};
					bpos_q <= pick_bit(lw, op_q.up);
					wd_q   <= rdata_q;
				end else begin
					status_q <= ST_NONE;
				end
			end
			B_OUT: begin
				if (slot_free) begin
					rsp_q.status      <= status_q;
					rsp_q.found_index <= fnd_q;
					rsp_q.bit_value   <= val_q;
					rsp_q.used_count  <= used_q;
				end
			end
			default: ;
		endcase
	end

	assign stat.size = size;
	assign stat.busy = (state_q == B_FILL) && !fill_rsp_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |-> (used_q <= size))
		else $error("used count exceeds map size");

	a_write_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WRITE && !cfg_wr) |=> (state_q == B_OUT))
		else $error("write did not lead to response");

	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == B_OUT))
		else $error("response raised outside output state");

endmodule

### sv/hierarchical_used_free_bitmap_core.sv
// ----------------------------------------------------------------------------
// hierarchical_used_free_bitmap_core
// Bitmap allocator with used/free summaries, searches, take/release and fill.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    hufb_pkg::req_t
//   rsp      out  rsp_valid/stall    hufb_pkg::rsp_t
//   cfg      in   cfg_valid/ready    cfg_data (bits_in_use)
//
// Set/clear add a write step when the bit changes, searches add a read step
// per summary level they descend and take/release add a write; the back pops
// a new request only once the last one has been answered. Fill requests sweep
// the leaf memory. After reset and after a cfg write a clearing pass over every
// leaf word runs and no request is accepted; cfg writes are always taken.
// A stalled response holds; up to two requests queue behind it.
// ----------------------------------------------------------------------------
module hierarchical_used_free_bitmap_core #(
	parameter int NBITS = hufb_pkg::NBITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  hufb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output hufb_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data
);
	import hufb_pkg::*;

	bk_stat_t stat;
	op_t      push_op, pop_op;
	logic     push, pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	hufb_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.stat      (stat),
		.q_full    (q_full),
		.push      (push),
		.push_op   (push_op)
	);

	hufb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	hufb_back #(.NBITS(NBITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_op      (pop_op),
		.pop       (pop),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### bench/tb_hierarchical_used_free_bitmap_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hierarchical_used_free_bitmap_core
// Drives bit requests, searches, take/release and fill through the request
// channel across several map sizes. A scoreboard keeps its own copy of the
// bitmap and its summaries and checks every response field against it.
// ----------------------------------------------------------------------------
module tb_hierarchical_used_free_bitmap_core;
	import hufb_pkg::*;

	localparam int NWORDS = 1024;
	localparam int NGROUPS = 32;
	localparam int CYCLE_LIMIT = 1000000;

	class bitmap_scoreboard;
		bit [31:0]   leaf[NWORDS];
		bit [31:0]   umid[NGROUPS];
		bit [31:0]   fmid[NGROUPS];
		bit [31:0]   utop;
		bit [31:0]   ftop;
		int unsigned used_total;
		int unsigned size_reg;
		rsp_t        want[$];
		int          errors;

		function new();
			size_reg = NBITS_DEF;
			errors = 0;
			fill(1'b0);
		endfunction

		function int unsigned size_now();
			return size_reg > NBITS_DEF ? NBITS_DEF : size_reg;
		endfunction

		function bit [31:0] range_mask(int unsigned w);
			int unsigned n;
			int unsigned base;
			n = size_now();
			base = w * 32;
			if (base >= n) return 32'd0;
			if (n - base >= 32) return MASK_ALL;
			return (32'd1 << (n - base)) - 32'd1;
		endfunction

		function bit [31:0] kind_word(bit used, int unsigned w);
			return used ? leaf[w] : (~leaf[w] & range_mask(w));
		endfunction

		function int unsigned lowest(bit [31:0] x);
			int unsigned i;
			i = 0;
			while (i < 31 && !x[i]) i++;
			return i;
		endfunction

		function int unsigned highest(bit [31:0] x);
			int unsigned i;
			i = 31;
			while (i > 0 && !x[i]) i--;
			return i;
		endfunction

		function void refresh(int unsigned w);
			int unsigned g;
			g = w >> 5;
			umid[g][w & 31] = leaf[w] != 0;
			fmid[g][w & 31] = kind_word(1'b0, w) != 0;
			utop[g] = umid[g] != 0;
			ftop[g] = fmid[g] != 0;
		endfunction

		function void fill(bit used);
			utop = 0;
			ftop = 0;
			foreach (umid[g]) begin
				umid[g] = 0;
				fmid[g] = 0;
			end
			for (int w = 0; w < NWORDS; w++) begin
				leaf[w] = used ? range_mask(w) : 32'd0;
				refresh(w);
			end
			used_total = used ? size_now() : 0;
		endfunction

		function int descend(bit used, int unsigned g, bit high);
			bit [31:0]   mid;
			bit [31:0]   m;
			int unsigned w;
			if (g >= NGROUPS) return -1;
			mid = used ? umid[g] : fmid[g];
			if (mid == 0) return -1;
			w = g * 32 + (high ? highest(mid) : lowest(mid));
			if (w >= NWORDS) return -1;
			m = kind_word(used, w);
			if (m == 0) return -1;
			return w * 32 + (high ? highest(m) : lowest(m));
		endfunction

		function int search_up(bit used, int unsigned p);
			int unsigned w;
			int unsigned g;
			int unsigned wb;
			int unsigned w2;
			bit [31:0]   m;
			bit [31:0]   lw;
			w = p >> 5;
			g = w >> 5;
			wb = (w & 31) + 1;
			m = kind_word(used, w) & (MASK_ALL << (p & 31));
			if (m != 0) return w * 32 + lowest(m);
			if (wb < 32) begin
				m = (used ? umid[g] : fmid[g]) & (MASK_ALL << wb);
				if (m != 0) begin
					w2 = g * 32 + lowest(m);
					if (w2 >= NWORDS) return -1;
					lw = kind_word(used, w2);
					if (lw == 0) return -1;
					return w2 * 32 + lowest(lw);
				end
			end
			if (g + 1 < 32) begin
				m = (used ? utop : ftop) & (MASK_ALL << (g + 1));
				if (m != 0) return descend(used, lowest(m), 1'b0);
			end
			return -1;
		endfunction

		function int search_down(bit used, int unsigned p);
			int unsigned w;
			int unsigned g;
			int unsigned wb;
			int unsigned w2;
			bit [31:0]   m;
			bit [31:0]   lw;
			w = p >> 5;
			g = w >> 5;
			wb = w & 31;
			m = kind_word(used, w) & (MASK_ALL >> (31 - (p & 31)));
			if (m != 0) return w * 32 + highest(m);
			if (wb > 0) begin
				m = (used ? umid[g] : fmid[g]) & (MASK_ALL >> (32 - wb));
				if (m != 0) begin
					w2 = g * 32 + highest(m);
					if (w2 >= NWORDS) return -1;
					lw = kind_word(used, w2);
					if (lw == 0) return -1;
					return w2 * 32 + highest(lw);
				end
			end
			if (g > 0) begin
				m = (used ? utop : ftop) & (MASK_ALL >> (32 - g));
				if (m != 0) return descend(used, highest(m), 1'b1);
			end
			return -1;
		endfunction

		function logic [1:0] write_bit(int unsigned idx, bit used);
			int unsigned w;
			w = idx >> 5;
			if (leaf[w][idx & 31] == used) return ST_SAME;
			leaf[w][idx & 31] = used;
			if (used) used_total++;
			else used_total--;
			refresh(w);
			return ST_DONE;
		endfunction

		function void configure(int unsigned v);
			size_reg = v & 16'hffff;
			fill(1'b0);
		endfunction

		function int pending();
			return want.size();
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			int unsigned n;
			int unsigned idx;
			int          hit;
			bit          search;
			n = size_now();
			idx = 32'(r.bit_index);
			e = '0;
			hit = -1;
			search = 0;
			case (r.req_type)
				RQ_SET, RQ_CLEAR, RQ_READ: begin
					e.found_index = 15'(idx);
					if (idx >= n) e.status = ST_RANGE;
					else if (r.req_type == RQ_READ) e.bit_value = leaf[idx >> 5][idx & 31];
					else e.status = write_bit(idx, r.req_type == RQ_SET);
				end
				RQ_LOW_FREE, RQ_TAKE_LOW: begin
					search = 1;
					if (n != 0) hit = search_up(1'b0, 0);
				end
				RQ_HIGH_FREE, RQ_TAKE_HIGH: begin
					search = 1;
					if (n != 0) hit = search_down(1'b0, n - 1);
				end
				RQ_LOW_USED, RQ_RELEASE_LOW: begin
					search = 1;
					if (n != 0) hit = search_up(1'b1, 0);
				end
				RQ_HIGH_USED, RQ_RELEASE_HIGH: begin
					search = 1;
					if (n != 0) hit = search_down(1'b1, n - 1);
				end
				RQ_NEXT_USED_UP, RQ_NEXT_USED_DN, RQ_NEXT_FREE_UP, RQ_NEXT_FREE_DN: begin
					if (idx >= n) begin
						e.status = ST_RANGE;
						e.found_index = 15'(idx);
					end else begin
						search = 1;
						case (r.req_type)
							RQ_NEXT_USED_UP: hit = search_up(1'b1, idx);
							RQ_NEXT_FREE_UP: hit = search_up(1'b0, idx);
							RQ_NEXT_USED_DN: hit = search_down(1'b1, idx);
							default: hit = search_down(1'b0, idx);
						endcase
					end
				end
				RQ_ALL_FREE: fill(1'b0);
				RQ_ALL_USED: fill(1'b1);
				default: ;
			endcase
			if (search) begin
				if (hit < 0) e.status = ST_NONE;
				else begin
					e.found_index = 15'(hit);
					if (r.req_type == RQ_TAKE_LOW || r.req_type == RQ_TAKE_HIGH)
						void'(write_bit(hit, 1'b1));
					if (r.req_type == RQ_RELEASE_LOW || r.req_type == RQ_RELEASE_HIGH)
						void'(write_bit(hit, 1'b0));
				end
			end
			e.used_count = 16'(used_total);
			want.push_back(e);
		endfunction

		function void check(rsp_t got);
			rsp_t e;
			if (want.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %p", got);
				return;
			end
			e = want.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp st=%0d idx=%0d val=%0d cnt=%0d, %s",
						e.status, e.found_index, e.bit_value, e.used_count,
						$sformatf("got st=%0d idx=%0d val=%0d cnt=%0d",
						got.status, got.found_index, got.bit_value, got.used_count));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	bitmap_scoreboard sb;
	int send_idle;
	int recv_idle;
	int hold_cycles;
	bit hold_start;
	int cycles;
	int sent;

	hierarchical_used_free_bitmap_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_start) begin
			hold_cycles = 400;
			hold_start = 0;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= $urandom_range(99) < recv_idle;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (rsp_valid && !rsp_stall) sb.check(rsp);
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// entered and left just after a falling edge
	task automatic send_req(logic [4:0] kind, logic [14:0] idx);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{req_type: kind, bit_index: idx};
		do @(posedge clk); while (req_stall);
		sb.note_request(req);
		sent++;
		if (sent == 650) begin
			send_idle = 70;
			recv_idle = 19;
		end else if (sent == 1300) begin
			send_idle = 0;
			recv_idle = 0;
		end
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_size(logic [15:0] v);
		drain();
		repeat (10) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.configure(32'(v));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_req();
		int unsigned n;
		int unsigned hi;
		int unsigned pick;
		logic [4:0]  kind;
		logic [14:0] idx;
		n = sb.size_now();
		hi = n + 3 > 32767 ? 32767 : n + 3;
		pick = $urandom_range(999);
		if (pick < 250) kind = RQ_SET;
		else if (pick < 400) kind = RQ_CLEAR;
		else if (pick < 470) kind = RQ_READ;
		else if (pick < 480) kind = $urandom_range(1) ? RQ_ALL_FREE : RQ_ALL_USED;
		else if (pick < 500) kind = 5'($urandom_range(31, 17));
		else if (pick < 700) kind = 5'($urandom_range(RQ_NEXT_FREE_DN, RQ_NEXT_USED_UP));
		else if (pick < 800) kind = 5'($urandom_range(RQ_HIGH_USED, RQ_LOW_FREE));
		else begin
			case ($urandom_range(3))
				0: kind = RQ_TAKE_LOW;
				1: kind = RQ_TAKE_HIGH;
				2: kind = RQ_RELEASE_LOW;
				default: kind = RQ_RELEASE_HIGH;
			endcase
		end
		if ($urandom_range(99) < 85) idx = 15'($urandom_range(hi, 0));
		else idx = 15'($urandom);
		send_req(kind, idx);
	endtask

	initial begin
		logic [15:0] sizes[8];
		sizes = '{16'd40, 16'd0, 16'd1, 16'd33, 16'd65535, 16'd1000, 16'd1025, 16'd32768};
		sb = new();
		send_idle = 19;
		recv_idle = 70;
		hold_cycles = 0;
		hold_start = 0;
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_req(RQ_SET, 15'd0);
		send_req(RQ_SET, 15'd32767);
		send_req(RQ_READ, 15'd32767);
		send_req(RQ_READ, 15'd1);
		send_req(RQ_SET, 15'd0);
		send_req(RQ_CLEAR, 15'd5);
		send_req(RQ_LOW_FREE, 15'd0);
		send_req(RQ_HIGH_FREE, 15'd0);
		send_req(RQ_LOW_USED, 15'd0);
		send_req(RQ_HIGH_USED, 15'd0);
		send_req(RQ_NEXT_USED_UP, 15'd1);
		send_req(RQ_NEXT_USED_DN, 15'd32766);
		send_req(RQ_NEXT_FREE_UP, 15'd0);
		send_req(RQ_NEXT_FREE_DN, 15'd32767);
		send_req(RQ_TAKE_LOW, 15'd0);
		send_req(RQ_TAKE_HIGH, 15'd0);
		send_req(RQ_RELEASE_LOW, 15'd0);
		send_req(RQ_RELEASE_HIGH, 15'd0);
		send_req(5'd17, 15'h5555);
		send_req(5'd31, 15'h2aaa);
		send_req(RQ_ALL_USED, 15'd0);
		send_req(RQ_HIGH_FREE, 15'd0);
		send_req(RQ_CLEAR, 15'd1234);
		send_req(RQ_NEXT_FREE_DN, 15'd32767);
		send_req(RQ_ALL_FREE, 15'd0);

		for (int p = 0; p <= 8; p++) begin
			if (p > 0) write_size(sizes[p - 1]);
			if (p == 2) hold_start = 1;
			for (int i = 0; i < 214; i++) begin
				random_req();
				if (p == 4 && i == 100) drain();
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

### filelist.f
sv/hufb_pkg.sv
sv/hufb_front.sv
sv/hufb_queue.sv
sv/hufb_back.sv
sv/hierarchical_used_free_bitmap_core.sv
bench/tb_hierarchical_used_free_bitmap_core.sv
